// ===== hw/rtl/avi_pkg.sv =====
// avi_pkg: shared types, constants and the microcode table of the velocity integrator
// used by avi_seq, avi_dp and accel_velocity_integrator_core
package avi_pkg;

  localparam int PC_W    = 5;
  localparam int DT_W    = 9;
  localparam int ACC_W   = 34;
  localparam int VEL_W   = 48;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HI_W    = 48;
  localparam int RSUM_W  = 49;

  localparam logic [15:0]      COUNT_SCALE_Q16 = 16'd31492;
  localparam logic [19:0]      GRAVITY_Q16     = 20'd642690;
  localparam logic [DT_W-1:0]  DT_MAX_MS       = 9'd500;
  localparam logic [DT_W-1:0]  DT_DEFAULT_MS   = 9'd10;
  localparam logic [PC_W-1:0]  PC_DONE         = 5'd31;

  typedef enum logic [3:0] {
    OP_DT,
    OP_MSCALE,
    OP_BIAS,
    OP_DBAND,
    OP_MDT,
    OP_ACCUM,
    OP_MAG,
    OP_MHI,
    OP_MLO,
    OP_SUM,
    OP_STORE,
    OP_DONE
  } avi_op_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } avi_axis_t;

  typedef struct packed {
    avi_op_t         op;
    avi_axis_t       axis;
    logic            jmp_cmd;
    logic [PC_W-1:0] target;
  } avi_uword_t;

  typedef struct packed {
    logic      run;
    avi_op_t   op;
    avi_axis_t axis;
  } avi_ctrl_t;

  typedef struct packed {
    logic cmd;
    logic out_full;
  } avi_stat_t;

  function automatic avi_uword_t avi_uw(input avi_op_t op, input avi_axis_t axis);
    avi_uword_t w;
    w.op      = op;
    w.axis    = axis;
    w.jmp_cmd = 1'b0;
    w.target  = '0;
    return w;
  endfunction

  function automatic avi_uword_t avi_ucode(input logic [PC_W-1:0] pc);
    avi_uword_t w;
    w = avi_uw(OP_DONE, AX_X);
    unique case (pc)
      5'd0: begin
        w = avi_uw(OP_DT, AX_X);
        w.jmp_cmd = 1'b1;
        w.target  = PC_DONE;
      end
      5'd1:  w = avi_uw(OP_MSCALE, AX_X);
      5'd2:  w = avi_uw(OP_BIAS,   AX_X);
      5'd3:  w = avi_uw(OP_DBAND,  AX_X);
      5'd4:  w = avi_uw(OP_MDT,    AX_X);
      5'd5:  w = avi_uw(OP_ACCUM,  AX_X);
      5'd6:  w = avi_uw(OP_MAG,    AX_X);
      5'd7:  w = avi_uw(OP_MHI,    AX_X);
      5'd8:  w = avi_uw(OP_MLO,    AX_X);
      5'd9:  w = avi_uw(OP_SUM,    AX_X);
      5'd10: w = avi_uw(OP_STORE,  AX_X);
      5'd11: w = avi_uw(OP_MSCALE, AX_Y);
      5'd12: w = avi_uw(OP_BIAS,   AX_Y);
      5'd13: w = avi_uw(OP_DBAND,  AX_Y);
      5'd14: w = avi_uw(OP_MDT,    AX_Y);
      5'd15: w = avi_uw(OP_ACCUM,  AX_Y);
      5'd16: w = avi_uw(OP_MAG,    AX_Y);
      5'd17: w = avi_uw(OP_MHI,    AX_Y);
      5'd18: w = avi_uw(OP_MLO,    AX_Y);
      5'd19: w = avi_uw(OP_SUM,    AX_Y);
      5'd20: w = avi_uw(OP_STORE,  AX_Y);
      5'd21: w = avi_uw(OP_MSCALE, AX_Z);
      5'd22: w = avi_uw(OP_BIAS,   AX_Z);
      5'd23: w = avi_uw(OP_DBAND,  AX_Z);
      5'd24: w = avi_uw(OP_MDT,    AX_Z);
      5'd25: w = avi_uw(OP_ACCUM,  AX_Z);
      5'd26: w = avi_uw(OP_MAG,    AX_Z);
      5'd27: w = avi_uw(OP_MHI,    AX_Z);
      5'd28: w = avi_uw(OP_MLO,    AX_Z);
      5'd29: w = avi_uw(OP_SUM,    AX_Z);
      5'd30: w = avi_uw(OP_STORE,  AX_Z);
      5'd31: w = avi_uw(OP_DONE,   AX_X);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/avi_seq.sv =====
// avi_seq: step counter and microcode lookup of the velocity integrator
// depends on avi_pkg for the control word table and control/status structs
module avi_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  avi_pkg::avi_stat_t stat,
  output avi_pkg::avi_ctrl_t ctrl
);
  import avi_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  avi_uword_t      uw;
  logic            held;
  logic            start;

  assign uw        = avi_ucode(pc_r);
  assign held      = (uw.op == OP_DONE) && stat.out_full;
  assign start     = in_valid && !busy_r;
  assign in_stall  = busy_r;
  assign ctrl.run  = busy_r && !held;
  assign ctrl.op   = uw.op;
  assign ctrl.axis = uw.axis;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (ctrl.run) begin
      if (uw.op == OP_DONE) begin
        busy_nxt = 1'b0;
      end else if (uw.jmp_cmd && stat.cmd) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  a_start_pc0: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && (pc_r == '0))
    else $error("transfer did not start program at step zero");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (uw.op == OP_DONE) && !stat.out_full |=> !busy_r)
    else $error("sequencer did not finish after done step");

  a_hold_pc: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && held |=> busy_r && $stable(pc_r))
    else $error("sequencer moved while result slot was full");

endmodule

// ===== hw/rtl/avi_dp.sv =====
// avi_dp: datapath of the velocity integrator with one shared multiplier
// depends on avi_pkg; driven by the control word from avi_seq
module avi_dp #(
  parameter logic [15:0] COUNT_SCALE = avi_pkg::COUNT_SCALE_Q16,
  parameter logic [19:0] GRAVITY     = avi_pkg::GRAVITY_Q16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  avi_pkg::avi_ctrl_t        ctrl,
  output avi_pkg::avi_stat_t        stat,
  input  logic                      in_accept,
  input  logic                      in_cmd,
  input  logic signed [15:0]        in_sample_x,
  input  logic signed [15:0]        in_sample_y,
  input  logic signed [15:0]        in_sample_z,
  input  logic [31:0]               in_time_ms,
  input  logic signed [31:0]        bias_x,
  input  logic signed [31:0]        bias_y,
  input  logic signed [31:0]        bias_z,
  input  logic [30:0]               dead_zone,
  input  logic [24:0]               decay_factor,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [47:0]        out_vel_x,
  output logic signed [47:0]        out_vel_y,
  output logic signed [47:0]        out_vel_z
);
  import avi_pkg::*;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [RSUM_W-1:0] MAG_LIM = {2'b01, {(VEL_W-1){1'b0}}};

  logic                       cmd_r, cmd_nxt;
  logic signed [15:0]         sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [31:0]                time_r, time_nxt;
  logic [31:0]                prev_time_r, prev_time_nxt;
  logic [DT_W-1:0]            dt_r, dt_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [VEL_W-1:0]    sum_r, sum_nxt;
  logic [VEL_W-1:0]           mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [HI_W-1:0]            hi_r, hi_nxt;
  logic [RSUM_W-1:0]          rsum_r, rsum_nxt;
  logic signed [VEL_W-1:0]    speed_x_r, speed_x_nxt;
  logic signed [VEL_W-1:0]    speed_y_r, speed_y_nxt;
  logic signed [VEL_W-1:0]    speed_z_r, speed_z_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [VEL_W-1:0]    vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt, vel_z_r, vel_z_nxt;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [15:0]         smp_sel;
  logic signed [31:0]         off_sel;
  logic signed [VEL_W-1:0]    spd_sel;
  logic signed [VEL_W-1:0]    spd_new;
  logic [31:0]                dt_full;
  logic signed [ACC_W-1:0]    grav_sel;
  logic signed [ACC_W:0]      db_sum;
  logic signed [VEL_W:0]      acc_sum;

  always_comb begin
    unique case (ctrl.axis)
      AX_X: begin
        smp_sel = sx_r;
        off_sel = bias_x;
        spd_sel = speed_x_r;
      end
      AX_Y: begin
        smp_sel = sy_r;
        off_sel = bias_y;
        spd_sel = speed_y_r;
      end
      AX_Z: begin
        smp_sel = sz_r;
        off_sel = bias_z;
        spd_sel = speed_z_r;
      end
      default: begin
        smp_sel = '0;
        off_sel = '0;
        spd_sel = '0;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (ctrl.op)
      OP_MSCALE: begin
        mul_a = MUL_A_W'(smp_sel);
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, COUNT_SCALE});
      end
      OP_MDT: begin
        mul_a = acc_r;
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_r});
      end
      OP_MHI: begin
        mul_a = $signed({{(MUL_A_W-24){1'b0}}, mag_r[47:24]});
        mul_b = $signed({1'b0, decay_factor});
      end
      OP_MLO: begin
        mul_a = $signed({{(MUL_A_W-24){1'b0}}, mag_r[23:0]});
        mul_b = $signed({1'b0, decay_factor});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign dt_full  = time_r - prev_time_r;
  assign grav_sel = (ctrl.axis == AX_Z) ? $signed({{(ACC_W-20){1'b0}}, GRAVITY}) : '0;
  assign db_sum   = {acc_r[ACC_W-1], acc_r} + $signed({{(ACC_W-30){1'b0}}, dead_zone});
  assign acc_sum  = {spd_sel[VEL_W-1], spd_sel}
                  + {{(VEL_W-42){prod_r[42]}}, prod_r[42:0]};

  always_comb begin
    if (neg_r) begin
      if (rsum_r > MAG_LIM) begin
        spd_new = VEL_MIN;
      end else begin
        spd_new = -$signed(rsum_r[VEL_W-1:0]);
      end
    end else if (rsum_r[RSUM_W-1:VEL_W-1] != 2'b00) begin
      spd_new = VEL_MAX;
    end else begin
      spd_new = $signed(rsum_r[VEL_W-1:0]);
    end
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    time_nxt      = time_r;
    prev_time_nxt = prev_time_r;
    dt_nxt        = dt_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    hi_nxt        = hi_r;
    rsum_nxt      = rsum_r;
    speed_x_nxt   = speed_x_r;
    speed_y_nxt   = speed_y_r;
    speed_z_nxt   = speed_z_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    vel_z_nxt     = vel_z_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      cmd_nxt  = in_cmd;
      sx_nxt   = in_sample_x;
      sy_nxt   = in_sample_y;
      sz_nxt   = in_sample_z;
      time_nxt = in_time_ms;
    end

    if (ctrl.run) begin
      unique case (ctrl.op)
        OP_DT: begin
          prev_time_nxt = time_r;
          if (dt_full == 32'd0 || dt_full > {{(32-DT_W){1'b0}}, DT_MAX_MS}) begin
            dt_nxt = DT_DEFAULT_MS;
          end else begin
            dt_nxt = dt_full[DT_W-1:0];
          end
          if (cmd_r) begin
            speed_x_nxt = '0;
            speed_y_nxt = '0;
            speed_z_nxt = '0;
          end
        end
        OP_MSCALE, OP_MDT, OP_MHI: begin
          prod_nxt = mul_p;
        end
        OP_BIAS: begin
          acc_nxt = ACC_W'($signed(prod_r[32:0])) - ACC_W'(off_sel) - grav_sel;
        end
        OP_DBAND: begin
          if (acc_r[ACC_W-1]) begin
            if (db_sum > 0) begin
              acc_nxt = '0;
            end
          end else if ({{(ACC_W-31){1'b0}}, dead_zone} > acc_r[ACC_W-1:0]) begin
            acc_nxt = '0;
          end
        end
        OP_ACCUM: begin
          if (acc_sum[VEL_W] != acc_sum[VEL_W-1]) begin
            sum_nxt = acc_sum[VEL_W] ? VEL_MIN : VEL_MAX;
          end else begin
            sum_nxt = acc_sum[VEL_W-1:0];
          end
        end
        OP_MAG: begin
          neg_nxt = sum_r[VEL_W-1];
          mag_nxt = sum_r[VEL_W-1] ? VEL_W'(-sum_r) : sum_r;
        end
        OP_MLO: begin
          hi_nxt   = prod_r[HI_W-1:0];
          prod_nxt = mul_p;
        end
        OP_SUM: begin
          rsum_nxt = {1'b0, hi_r} + {{(RSUM_W-25){1'b0}}, prod_r[48:24]};
        end
        OP_STORE: begin
          unique case (ctrl.axis)
            AX_X:    speed_x_nxt = spd_new;
            AX_Y:    speed_y_nxt = spd_new;
            AX_Z:    speed_z_nxt = spd_new;
            default: speed_x_nxt = speed_x_r;
          endcase
        end
        OP_DONE: begin
          vel_x_nxt     = speed_x_r;
          vel_y_nxt     = speed_y_r;
          vel_z_nxt     = speed_z_r;
          out_valid_nxt = 1'b1;
        end
        default: begin
          prod_nxt = prod_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      speed_x_r   <= '0;
      speed_y_r   <= '0;
      speed_z_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_time_r <= prev_time_nxt;
      speed_x_r   <= speed_x_nxt;
      speed_y_r   <= speed_y_nxt;
      speed_z_r   <= speed_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sz_r   <= sz_nxt;
    time_r <= time_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    hi_r   <= hi_nxt;
    rsum_r <= rsum_nxt;
    vel_x_r <= vel_x_nxt;
    vel_y_r <= vel_y_nxt;
    vel_z_r <= vel_z_nxt;
  end

  assign stat.cmd      = cmd_r;
  assign stat.out_full = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_vel_x     = vel_x_r;
  assign out_vel_y     = vel_y_r;
  assign out_vel_z     = vel_z_r;

endmodule

// ===== hw/rtl/accel_velocity_integrator_core.sv =====
// accel_velocity_integrator_core: leaky three-axis velocity integrator with deadband
// one transfer at a time: in_stall holds the input until the 32-step microprogram, which runs
// every product of all three axes through one shared multiplier, reaches its done step and
// hands over its result; a reset command jumps from the first step straight to done
// reset (rst_n low, synchronous): velocities, stored tick and sequencer cleared, config registers to defaults
// depends on avi_pkg, avi_seq and avi_dp
module accel_velocity_integrator_core #(
  parameter logic [15:0] COUNT_SCALE = avi_pkg::COUNT_SCALE_Q16,
  parameter logic [19:0] GRAVITY     = avi_pkg::GRAVITY_Q16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic signed [15:0] in_sample_z,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_vel_x,
  output logic signed [47:0] out_vel_y,
  output logic signed [47:0] out_vel_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import avi_pkg::*;

  localparam logic [2:0] CFG_BIAS_X    = 3'd0;
  localparam logic [2:0] CFG_BIAS_Y    = 3'd1;
  localparam logic [2:0] CFG_BIAS_Z    = 3'd2;
  localparam logic [2:0] CFG_DEAD_ZONE = 3'd3;
  localparam logic [2:0] CFG_DECAY     = 3'd4;

  logic signed [31:0] bias_x_r, bias_y_r, bias_z_r;
  logic [30:0]        dead_zone_r;
  logic [24:0]        decay_factor_r;
  logic               in_accept;
  avi_ctrl_t          ctrl;
  avi_stat_t          stat;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r       <= '0;
      bias_y_r       <= '0;
      bias_z_r       <= '0;
      dead_zone_r    <= 31'd32768;
      decay_factor_r <= 25'd16775538;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIAS_X:    bias_x_r       <= $signed(cfg_data);
        CFG_BIAS_Y:    bias_y_r       <= $signed(cfg_data);
        CFG_BIAS_Z:    bias_z_r       <= $signed(cfg_data);
        CFG_DEAD_ZONE: dead_zone_r    <= cfg_data[30:0];
        CFG_DECAY:     decay_factor_r <= cfg_data[24:0];
        default:       dead_zone_r    <= dead_zone_r;
      endcase
    end
  end

  avi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  avi_dp #(
    .COUNT_SCALE (COUNT_SCALE),
    .GRAVITY     (GRAVITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_accept    (in_accept),
    .in_cmd       (in_cmd),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_sample_z  (in_sample_z),
    .in_time_ms   (in_time_ms),
    .bias_x       (bias_x_r),
    .bias_y       (bias_y_r),
    .bias_z       (bias_z_r),
    .dead_zone    (dead_zone_r),
    .decay_factor (decay_factor_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_vel_x    (out_vel_x),
    .out_vel_y    (out_vel_y),
    .out_vel_z    (out_vel_z)
  );

endmodule
